// ----- rtl/core/u2dcp_pkg.sv -----
// Shared types and constants for the UTF-8 to display code page converter.
// No dependencies.
package u2dcp_pkg;

    localparam logic [7:0] ASCII_LIMIT = 8'd128;
    localparam logic [7:0] LEAD_THREE  = 8'd225;
    localparam logic [7:0] MID_LOW     = 8'd186;
    localparam logic [7:0] MID_HIGH    = 8'd187;
    localparam logic [7:0] ESC_CODE    = 8'd255;
    localparam logic [8:0] ESC_LIMIT   = 9'd254;
    localparam logic [8:0] ESC_OFFSET  = 9'd255;

    typedef enum logic [1:0] {
        PH_LEAD      = 2'd0,
        PH_TWO       = 2'd1,
        PH_THREE     = 2'd2,
        PH_THREE_MID = 2'd3
    } t_phase;

    // Result words caused by one input word; terminator (if any) is last.
    typedef struct packed {
        logic [1:0]      cnt;
        logic            term;
        logic [2:0][7:0] code;
    } t_bundle;

endpackage

// ----- rtl/core/u2dcp_decode.sv -----
// Sequence decoder: lead/continuation tracking and code page lookup.
// Depends on u2dcp_pkg.
module u2dcp_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output u2dcp_pkg::t_bundle   o_res
);

    function automatic logic [8:0] lookup2(input logic [7:0] lead, input logic [7:0] tail);
        logic [8:0] c;
        c = 9'd0;
        case (lead)
            8'd195: begin
                case (tail)
                    8'd161: c = 9'd128;  8'd160: c = 9'd129;  8'd163: c = 9'd132;
                    8'd162: c = 9'd139;  8'd169: c = 9'd146;  8'd168: c = 9'd147;
                    8'd170: c = 9'd151;  8'd173: c = 9'd157;  8'd172: c = 9'd158;
                    8'd179: c = 9'd162;  8'd178: c = 9'd163;  8'd181: c = 9'd166;
                    8'd180: c = 9'd167;  8'd186: c = 9'd179;  8'd185: c = 9'd180;
                    8'd189: c = 9'd190;  8'd129: c = 9'd195;  8'd128: c = 9'd196;
                    8'd131: c = 9'd199;  8'd130: c = 9'd206;  8'd137: c = 9'd213;
                    8'd136: c = 9'd214;  8'd138: c = 9'd218;  8'd141: c = 9'd224;
                    8'd140: c = 9'd225;  8'd147: c = 9'd229;  8'd146: c = 9'd230;
                    8'd149: c = 9'd233;  8'd148: c = 9'd234;  8'd154: c = 9'd246;
                    8'd153: c = 9'd247;  8'd157: c = 9'd258;
                    default: c = 9'd0;
                endcase
            end
            8'd196: begin
                case (tail)
                    8'd131: c = 9'd133;  8'd169: c = 9'd161;  8'd145: c = 9'd145;
                    8'd130: c = 9'd200;  8'd144: c = 9'd212;  8'd168: c = 9'd228;
                    default: c = 9'd0;
                endcase
            end
            8'd197: begin
                case (tail)
                    8'd169: c = 9'd183;  8'd168: c = 9'd250;
                    default: c = 9'd0;
                endcase
            end
            8'd198: begin
                case (tail)
                    8'd161: c = 9'd173;  8'd176: c = 9'd184;  8'd160: c = 9'd240;
                    8'd175: c = 9'd251;
                    default: c = 9'd0;
                endcase
            end
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [8:0] lookup3(input logic [7:0] mid, input logic [7:0] tail);
        logic [8:0] c;
        c = 9'd0;
        case (mid)
            u2dcp_pkg::MID_LOW: begin
                case (tail)
                    8'd161: c = 9'd130;  8'd163: c = 9'd131;  8'd165: c = 9'd140;
                    8'd167: c = 9'd141;  8'd173: c = 9'd142;  8'd169: c = 9'd143;
                    8'd171: c = 9'd144;  8'd175: c = 9'd134;  8'd177: c = 9'd135;
                    8'd183: c = 9'd136;  8'd179: c = 9'd137;  8'd181: c = 9'd138;
                    8'd185: c = 9'd148;  8'd187: c = 9'd149;  8'd189: c = 9'd150;
                    8'd191: c = 9'd152;  8'd160: c = 9'd197;  8'd162: c = 9'd198;
                    8'd174: c = 9'd201;  8'd176: c = 9'd202;  8'd182: c = 9'd203;
                    8'd178: c = 9'd204;  8'd180: c = 9'd205;  8'd164: c = 9'd207;
                    8'd166: c = 9'd208;  8'd172: c = 9'd209;  8'd168: c = 9'd210;
                    8'd170: c = 9'd211;  8'd184: c = 9'd215;  8'd186: c = 9'd216;
                    8'd188: c = 9'd217;  8'd190: c = 9'd219;
                    default: c = 9'd0;
                endcase
            end
            u2dcp_pkg::MID_HIGH: begin
                case (tail)
                    8'd129: c = 9'd153;  8'd135: c = 9'd154;  8'd131: c = 9'd155;
                    8'd133: c = 9'd156;  8'd139: c = 9'd159;  8'd137: c = 9'd160;
                    8'd141: c = 9'd164;  8'd143: c = 9'd165;  8'd145: c = 9'd168;
                    8'd147: c = 9'd169;  8'd153: c = 9'd170;  8'd149: c = 9'd171;
                    8'd151: c = 9'd172;  8'd155: c = 9'd174;  8'd157: c = 9'd175;
                    8'd163: c = 9'd176;  8'd159: c = 9'd177;  8'd161: c = 9'd178;
                    8'd165: c = 9'd181;  8'd167: c = 9'd182;  8'd169: c = 9'd185;
                    8'd171: c = 9'd186;  8'd177: c = 9'd187;  8'd173: c = 9'd188;
                    8'd175: c = 9'd189;  8'd179: c = 9'd191;  8'd181: c = 9'd192;
                    8'd183: c = 9'd193;  8'd185: c = 9'd194;  8'd128: c = 9'd220;
                    8'd134: c = 9'd221;  8'd130: c = 9'd222;  8'd132: c = 9'd223;
                    8'd138: c = 9'd226;  8'd136: c = 9'd227;  8'd140: c = 9'd231;
                    8'd142: c = 9'd232;  8'd144: c = 9'd235;  8'd146: c = 9'd236;
                    8'd152: c = 9'd237;  8'd148: c = 9'd238;  8'd150: c = 9'd239;
                    8'd154: c = 9'd241;  8'd156: c = 9'd242;  8'd162: c = 9'd243;
                    8'd158: c = 9'd244;  8'd160: c = 9'd245;  8'd164: c = 9'd248;
                    8'd166: c = 9'd249;  8'd168: c = 9'd252;  8'd170: c = 9'd253;
                    8'd176: c = 9'd254;  8'd172: c = 9'd256;  8'd174: c = 9'd257;
                    8'd178: c = 9'd259;  8'd180: c = 9'd260;  8'd182: c = 9'd261;
                    8'd184: c = 9'd262;
                    default: c = 9'd0;
                endcase
            end
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    u2dcp_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_lead, n_lead;
    logic [7:0]        r_second, n_second;

    logic [8:0] sel_code;
    logic       sel_esc;
    logic       mid_ok;
    logic [1:0] dn;
    logic [7:0] d0, d1;

    assign mid_ok   = (r_second == u2dcp_pkg::MID_LOW) || (r_second == u2dcp_pkg::MID_HIGH);
    assign sel_code = (r_phase == u2dcp_pkg::PH_TWO) ? lookup2(r_lead, i_byte)
                                                      : lookup3(r_second, i_byte);
    assign sel_esc  = sel_code > u2dcp_pkg::ESC_LIMIT;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_lead   = r_lead;
        n_second = r_second;
        case (r_phase)
            u2dcp_pkg::PH_LEAD: begin
                if (i_byte >= u2dcp_pkg::ASCII_LIMIT && !i_end) begin
                    n_lead  = i_byte;
                    n_phase = (i_byte < u2dcp_pkg::LEAD_THREE) ? u2dcp_pkg::PH_TWO
                                                               : u2dcp_pkg::PH_THREE;
                end
            end
            u2dcp_pkg::PH_THREE: begin
                if (!i_end) begin
                    n_second = i_byte;
                    n_phase  = u2dcp_pkg::PH_THREE_MID;
                end
            end
            default: n_phase = u2dcp_pkg::PH_LEAD;
        endcase
        if (i_end) n_phase = u2dcp_pkg::PH_LEAD;
        if (n_phase == u2dcp_pkg::PH_LEAD) begin
            n_lead   = 8'd0;
            n_second = 8'd0;
        end
    end

    // data results for this word
    always_comb begin
        dn = 2'd0;
        d0 = 8'd0;
        d1 = 8'd0;
        case (r_phase)
            u2dcp_pkg::PH_LEAD: begin
                if (i_byte < u2dcp_pkg::ASCII_LIMIT) begin
                    dn = 2'd1;
                    d0 = i_byte;
                end else if (i_byte < u2dcp_pkg::LEAD_THREE && i_end) begin
                    dn = 2'd1;
                end
            end
            u2dcp_pkg::PH_TWO: begin
                if (sel_esc) begin
                    dn = 2'd2;
                    d0 = u2dcp_pkg::ESC_CODE;
                    d1 = 8'(sel_code - u2dcp_pkg::ESC_OFFSET);
                end else begin
                    dn = 2'd1;
                    d0 = sel_code[7:0];
                end
            end
            u2dcp_pkg::PH_THREE: begin
                if (i_end && r_lead == u2dcp_pkg::LEAD_THREE) dn = 2'd1;
            end
            u2dcp_pkg::PH_THREE_MID: begin
                if (r_lead == u2dcp_pkg::LEAD_THREE) begin
                    if (mid_ok && sel_esc) begin
                        dn = 2'd2;
                        d0 = u2dcp_pkg::ESC_CODE;
                        d1 = 8'(sel_code - u2dcp_pkg::ESC_OFFSET);
                    end else begin
                        dn = 2'd1;
                        d0 = mid_ok ? sel_code[7:0] : 8'd0;
                    end
                end
            end
            default: dn = 2'd0;
        endcase
    end

    assign o_res.cnt     = dn + {1'b0, i_end};
    assign o_res.term    = i_end;
    assign o_res.code[0] = d0;
    assign o_res.code[1] = (dn == 2'd2) ? d1 : 8'd0;
    assign o_res.code[2] = 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= u2dcp_pkg::PH_LEAD;
            r_lead   <= 8'd0;
            r_second <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_lead   <= n_lead;
            r_second <= n_second;
        end
    end

endmodule

// ----- rtl/core/u2dcp_outbuf.sv -----
// Result register: holds the words of one input word and sends them one a cycle while i_stall is low.
// Depends on u2dcp_pkg.
module u2dcp_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  u2dcp_pkg::t_bundle   i_bundle,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_code_byte,
    output logic                 o_is_terminator,
    output logic                 o_run_last
);

    logic            r_full;
    logic [1:0]      r_idx;
    logic [1:0]      r_cnt;
    logic            r_term;
    logic [2:0][7:0] r_code;
    logic            take;
    logic            last;

    assign last    = r_idx == 2'(r_cnt - 2'd1);
    assign take    = r_full && !i_stall;
    assign o_ready = !r_full || (take && last);

    assign o_valid         = r_full;
    assign o_code_byte     = r_code[r_idx];
    assign o_run_last      = last;
    assign o_is_terminator = r_term && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_full <= 1'b1;
            r_idx  <= 2'd0;
        end else if (take) begin
            if (last) begin
                r_full <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt  <= i_bundle.cnt;
            r_term <= i_bundle.term;
            r_code <= i_bundle.code;
        end
    end

endmodule

// ----- rtl/core/utf8_to_display_code_page_top.sv -----
// Path: each input word is held in the input register, decoded, then loaded into the result register.
// Throughput: one input word per cycle while each gives at most one result and the output is not stalled;
// a word that gives more than one result holds the result register until all of them are taken.
// Reset: synchronous, active low; clears the sequence state and valid flags.
// Depends on u2dcp_pkg, u2dcp_decode, u2dcp_outbuf.
module utf8_to_display_code_page_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_code_byte,
    output logic       o_is_terminator,
    output logic       o_run_last
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_end;
    logic               buf_ready;
    logic               adv;
    logic               in_take;
    u2dcp_pkg::t_bundle res;

    assign adv     = r_in_valid && buf_ready;
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_string_end;
        end
    end

    u2dcp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_res   (res)
    );

    u2dcp_outbuf u_outbuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (adv && (res.cnt != 2'd0)),
        .i_bundle        (res),
        .o_ready         (buf_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_byte     (o_code_byte),
        .o_is_terminator (o_is_terminator),
        .o_run_last      (o_run_last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for utf8_to_display_code_page_top: drives UTF-8 strings one word at a time
// and checks each display code word against a predictor kept in a small scoreboard class.
// Depends on u2dcp_pkg and the RTL of the converter.
module testbench;

    localparam int MAP_ENTRIES = 134;
    // lead, mid, tail, code; mid is 0 for two-byte sequences
    localparam int CODE_MAP [0:4*MAP_ENTRIES-1] = '{
        195,0,161,128, 195,0,160,129, 195,0,163,132, 195,0,162,139,
        195,0,169,146, 195,0,168,147, 195,0,170,151, 195,0,173,157,
        195,0,172,158, 195,0,179,162, 195,0,178,163, 195,0,181,166,
        195,0,180,167, 195,0,186,179, 195,0,185,180, 195,0,189,190,
        195,0,129,195, 195,0,128,196, 195,0,131,199, 195,0,130,206,
        195,0,137,213, 195,0,136,214, 195,0,138,218, 195,0,141,224,
        195,0,140,225, 195,0,147,229, 195,0,146,230, 195,0,149,233,
        195,0,148,234, 195,0,154,246, 195,0,153,247, 195,0,157,258,
        196,0,131,133, 196,0,169,161, 196,0,145,145, 196,0,130,200,
        196,0,144,212, 196,0,168,228,
        197,0,169,183, 197,0,168,250,
        198,0,161,173, 198,0,176,184, 198,0,160,240, 198,0,175,251,
        225,186,161,130, 225,186,163,131, 225,186,165,140, 225,186,167,141,
        225,186,173,142, 225,186,169,143, 225,186,171,144, 225,186,175,134,
        225,186,177,135, 225,186,183,136, 225,186,179,137, 225,186,181,138,
        225,186,185,148, 225,186,187,149, 225,186,189,150, 225,186,191,152,
        225,186,160,197, 225,186,162,198, 225,186,174,201, 225,186,176,202,
        225,186,182,203, 225,186,178,204, 225,186,180,205, 225,186,164,207,
        225,186,166,208, 225,186,172,209, 225,186,168,210, 225,186,170,211,
        225,186,184,215, 225,186,186,216, 225,186,188,217, 225,186,190,219,
        225,187,129,153, 225,187,135,154, 225,187,131,155, 225,187,133,156,
        225,187,139,159, 225,187,137,160, 225,187,141,164, 225,187,143,165,
        225,187,145,168, 225,187,147,169, 225,187,153,170, 225,187,149,171,
        225,187,151,172, 225,187,155,174, 225,187,157,175, 225,187,163,176,
        225,187,159,177, 225,187,161,178, 225,187,165,181, 225,187,167,182,
        225,187,169,185, 225,187,171,186, 225,187,177,187, 225,187,173,188,
        225,187,175,189, 225,187,179,191, 225,187,181,192, 225,187,183,193,
        225,187,185,194, 225,187,128,220, 225,187,134,221, 225,187,130,222,
        225,187,132,223, 225,187,138,226, 225,187,136,227, 225,187,140,231,
        225,187,142,232, 225,187,144,235, 225,187,146,236, 225,187,152,237,
        225,187,148,238, 225,187,150,239, 225,187,154,241, 225,187,156,242,
        225,187,162,243, 225,187,158,244, 225,187,160,245, 225,187,164,248,
        225,187,166,249, 225,187,168,252, 225,187,170,253, 225,187,176,254,
        225,187,172,256, 225,187,174,257, 225,187,178,259, 225,187,180,260,
        225,187,182,261, 225,187,184,262
    };

    typedef struct packed {
        logic [7:0] code;
        logic       term;
        logic       last;
    } t_code_word;

    class code_page_board;
        u2dcp_pkg::t_phase ph;
        logic [7:0]   lead;
        logic [7:0]   second;
        t_code_word   due_words[$];
        t_code_word   step_words[$];
        int           errors;

        function new();
            ph     = u2dcp_pkg::PH_LEAD;
            lead   = 8'd0;
            second = 8'd0;
            errors = 0;
        endfunction

        function logic [8:0] lookup(logic [7:0] a, logic [7:0] m, logic [7:0] t);
            for (int k = 0; k < MAP_ENTRIES; k++) begin
                if (CODE_MAP[4*k] == a && CODE_MAP[4*k+1] == m && CODE_MAP[4*k+2] == t)
                    return 9'(CODE_MAP[4*k+3]);
            end
            return 9'd0;
        endfunction

        function void push_word(logic [7:0] code, logic term);
            t_code_word w;
            w.code = code;
            w.term = term;
            w.last = 1'b0;
            step_words.push_back(w);
        endfunction

        function void push_code(logic [8:0] code);
            logic [8:0] reduced;
            reduced = code - u2dcp_pkg::ESC_OFFSET;
            if (code > u2dcp_pkg::ESC_LIMIT) begin
                push_word(u2dcp_pkg::ESC_CODE, 1'b0);
                push_word(reduced[7:0], 1'b0);
            end else begin
                push_word(code[7:0], 1'b0);
            end
        endfunction

        function void note_byte(logic [7:0] val, logic fin);
            step_words.delete();
            case (ph)
                u2dcp_pkg::PH_LEAD: begin
                    if (val < u2dcp_pkg::ASCII_LIMIT) begin
                        push_word(val, 1'b0);
                    end else if (val < u2dcp_pkg::LEAD_THREE) begin
                        if (fin) begin
                            push_word(8'd0, 1'b0);
                        end else begin
                            lead = val;
                            ph   = u2dcp_pkg::PH_TWO;
                        end
                    end else if (!fin) begin
                        lead = val;
                        ph   = u2dcp_pkg::PH_THREE;
                    end
                end
                u2dcp_pkg::PH_TWO: begin
                    push_code(lookup(lead, 8'd0, val));
                    ph = u2dcp_pkg::PH_LEAD;
                end
                u2dcp_pkg::PH_THREE: begin
                    if (fin) begin
                        if (lead == u2dcp_pkg::LEAD_THREE)
                            push_word(8'd0, 1'b0);
                    end else begin
                        second = val;
                        ph     = u2dcp_pkg::PH_THREE_MID;
                    end
                end
                default: begin
                    if (lead == u2dcp_pkg::LEAD_THREE) begin
                        if (second == u2dcp_pkg::MID_LOW || second == u2dcp_pkg::MID_HIGH)
                            push_code(lookup(u2dcp_pkg::LEAD_THREE, second, val));
                        else
                            push_word(8'd0, 1'b0);
                    end
                    ph = u2dcp_pkg::PH_LEAD;
                end
            endcase
            if (fin) begin
                push_word(8'd0, 1'b1);
                ph = u2dcp_pkg::PH_LEAD;
            end
            if (ph == u2dcp_pkg::PH_LEAD) begin
                lead   = 8'd0;
                second = 8'd0;
            end
            if (step_words.size() > 0)
                step_words[step_words.size()-1].last = 1'b1;
            foreach (step_words[i])
                due_words.push_back(step_words[i]);
        endfunction

        function void check_word(logic [7:0] code, logic term, logic last);
            t_code_word w;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected word code=%0d term=%0b last=%0b",
                             code, term, last);
                return;
            end
            w = due_words.pop_front();
            if (code !== w.code || term !== w.term || last !== w.last) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: word mismatch: exp code=%0d term=%0b last=%0b,",
                              " got code=%0d term=%0b last=%0b"},
                             w.code, w.term, w.last, code, term, last);
            end
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] in_byte = 8'd1;
    logic       string_end = 1'b0;
    logic       word_valid;
    logic       word_stall = 1'b0;
    logic [7:0] code_byte;
    logic       is_term;
    logic       run_last;

    code_page_board board;
    int         idle_pct = 25;
    int         sent = 0;

    utf8_to_display_code_page_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (byte_valid),
        .o_stall         (byte_stall),
        .i_in_byte       (in_byte),
        .i_string_end    (string_end),
        .o_valid         (word_valid),
        .i_stall         (word_stall),
        .o_code_byte     (code_byte),
        .o_is_terminator (is_term),
        .o_run_last      (run_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #500000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge clk) begin
        word_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && word_valid === 1'b1 && !word_stall)
            board.check_word(code_byte, is_term, run_last);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(logic [7:0] val, logic fin);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= val;
        string_end <= fin;
        do @(posedge clk); while (byte_stall);
        board.note_byte(val, fin);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        do @(negedge clk); while (board.pending() != 0);
    endtask

    task automatic send_random_string();
        logic [7:0] str[$];
        int         n_chars;
        int         kind;
        int         k;
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                str.push_back(8'($urandom_range(1, 127)));
            end else if (kind < 60) begin
                k = $urandom_range(0, MAP_ENTRIES - 1);
                str.push_back(8'(CODE_MAP[4*k]));
                if (CODE_MAP[4*k+1] != 0)
                    str.push_back(8'(CODE_MAP[4*k+1]));
                str.push_back(8'(CODE_MAP[4*k+2]));
            end else if (kind < 72) begin
                str.push_back(8'($urandom_range(128, 224)));
                str.push_back(8'($urandom_range(1, 255)));
            end else if (kind < 82) begin
                str.push_back(8'($urandom_range(225, 255)));
                str.push_back(8'($urandom_range(1, 255)));
                str.push_back(8'($urandom_range(1, 255)));
            end else begin
                str.push_back(8'($urandom_range(1, 255)));
            end
        end
        // cut the string short now and then, often mid-sequence
        if (str.size() > 1 && $urandom_range(0, 4) == 0) begin
            k = $urandom_range(1, str.size() - 1);
            while (str.size() > k)
                void'(str.pop_back());
        end
        foreach (str[i])
            send_byte(str[i], i == str.size() - 1);
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        board  = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ASCII extremes, terminator after plain data
        send_byte(8'd1, 1'b1);
        send_byte(8'd127, 1'b0);
        // two-byte code needing escape
        send_byte(8'd195, 1'b0); send_byte(8'd157, 1'b0);
        // three-byte codes, escaped and plain, string closed on the tail
        send_byte(8'd225, 1'b0); send_byte(8'd187, 1'b0); send_byte(8'd184, 1'b0);
        send_byte(8'd225, 1'b0); send_byte(8'd186, 1'b0); send_byte(8'd161, 1'b1);
        // unknown pair, follower below 128 consumed anyway
        send_byte(8'd196, 1'b0); send_byte(8'd65, 1'b0);
        // two-byte leads as last word
        send_byte(8'd128, 1'b1);
        send_byte(8'd224, 1'b1);
        // three-byte leads as last word
        send_byte(8'd225, 1'b1);
        send_byte(8'd255, 1'b1);
        // 225 cut after its second word
        send_byte(8'd225, 1'b0); send_byte(8'd186, 1'b1);
        // other three-byte lead cut after its second word
        send_byte(8'd230, 1'b0); send_byte(8'd1, 1'b1);
        // 225 with a bad middle word
        send_byte(8'd225, 1'b0); send_byte(8'd200, 1'b0); send_byte(8'd100, 1'b0);
        // other three-byte lead, complete, closing the string
        send_byte(8'd240, 1'b0); send_byte(8'd128, 1'b0); send_byte(8'd255, 1'b1);
        wait_drained();

        while (sent < 100) begin
            idle_pct = (sent >= 60 && sent < 90) ? 0 : 25;
            send_random_string();
            if (!paused && sent >= 95) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        idle_pct = 25;
        wait_drained();
        repeat (8) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
